[rtl/core/joystick_input_conditioner_assert.svh]
// Assertion macros for the joystick input conditioner.
`ifndef JOYSTICK_INPUT_CONDITIONER_ASSERT_SVH
`define JOYSTICK_INPUT_CONDITIONER_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define JIC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("joystick_input_conditioner: assertion failed");
// Consequent holds whenever the antecedent holds.
`define JIC_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("joystick_input_conditioner: assertion failed");
// Consequent holds in the cycle after the antecedent.
`define JIC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("joystick_input_conditioner: assertion failed");
`else
`define JIC_ASSERT(label, clk, rst, prop)
`define JIC_ASSERT_IMPL(label, clk, rst, pre, post)
`define JIC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/core/jic_pkg.sv]
// Types and constants shared by the joystick input conditioner.
`timescale 1ns / 1ps
`default_nettype none
package jic_pkg;

   localparam int FIELD_BUTTONS = 4;
   localparam int AXIS_SHIFT    = 7;

   localparam logic [7:0] BYTE_ESC   = 8'd27;
   localparam logic [7:0] BYTE_CSI   = 8'd91;
   localparam logic [7:0] KEY_UP     = 8'd65;
   localparam logic [7:0] KEY_DOWN   = 8'd66;
   localparam logic [7:0] KEY_RIGHT  = 8'd67;
   localparam logic [7:0] KEY_LEFT   = 8'd68;

   localparam logic [2:0] POS_MIN    = 3'd0;
   localparam logic [2:0] POS_MAX    = 3'd7;
   localparam logic [2:0] POS_CENTER = 3'd3;
   localparam logic [2:0] POS_LOW    = 3'd1;
   localparam logic [2:0] POS_HIGH   = 3'd6;

   localparam logic [7:0] DEBOUNCE_LIMIT_RESET = 8'd8;

   localparam logic [3:0] CSR_DEBOUNCE_LIMIT     = 4'd0;
   localparam logic [3:0] CSR_SERIAL_KEYS_ENABLE = 4'd1;

   typedef struct packed {
      logic [3:0] button_levels;
      logic [9:0] x_sample;
      logic [9:0] y_sample;
      logic       seq_ready;
      logic [7:0] seq_first;
      logic [7:0] seq_second;
      logic [7:0] seq_third;
   } req_type;

   typedef struct packed {
      logic [2:0] x_pos;
      logic [2:0] y_pos;
      logic [3:0] buttons_pressed;
      logic       changed;
      logic       dir_left;
      logic       dir_right;
      logic       dir_up;
      logic       dir_down;
      logic       seq_consumed;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_BUTTONS-1:0] pressed;
      logic                     changed;
   } btn_status_type;

endpackage
`default_nettype wire

[rtl/core/jic_debounce.sv]
// Saturating up/down debounce counters, one per button.
`timescale 1ns / 1ps
`default_nettype none
module jic_debounce #(
   parameter int NUM_BUTTONS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic [jic_pkg::FIELD_BUTTONS-1:0]   levels,
   input  wire logic [7:0]                          limit,
   output jic_pkg::btn_status_type                  status
);

   logic [7:0]             cnt_ff [NUM_BUTTONS];
   logic [7:0]             cnt_in [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] chg;
   logic [NUM_BUTTONS-1:0] low;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      if (i < jic_pkg::FIELD_BUTTONS) begin : g_pin
         assign low[i] = ~levels[i];
      end else begin : g_none
         assign low[i] = 1'b0;
      end

      always_comb begin
         cnt_in[i] = cnt_ff[i];
         chg[i]    = 1'b0;
         if (low[i]) begin
            if (cnt_ff[i] < limit) begin
               cnt_in[i] = cnt_ff[i] + 8'd1;
               chg[i]    = (cnt_in[i] >= limit);
            end
         end else begin
            if (cnt_ff[i] != 8'd0) begin
               cnt_in[i] = cnt_ff[i] - 8'd1;
               chg[i]    = (cnt_in[i] == 8'd0);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= 8'd0;
         end else if (advance) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   for (genvar j = 0; j < jic_pkg::FIELD_BUTTONS; j++) begin : g_out
      if (j < NUM_BUTTONS) begin : g_real
         assign status.pressed[j] = (cnt_in[j] >= limit);
      end else begin : g_absent
         assign status.pressed[j] = 1'b0;
      end
   end

   assign status.changed = |chg;

endmodule
`default_nettype wire

[rtl/core/joystick_input_conditioner.sv]
// Top level of the joystick input conditioner.
// Usage:
//   req_* carries one poll tick (buttons, axis samples, serial bytes) per item;
//   rsp_* returns exactly one conditioned result per item, in order.
//   An item moves when valid is high and stall is low at a clock edge.
//   csr_* writes debounce_limit (index 0) and serial_keys_enable (index 1);
//   csr_ready is always high, other indexes are ignored.
// Timing:
//   An accepted item is held in one input register, then in one result
//   register, with the single-pass logic between them. Throughput is one
//   item per cycle unless rsp_stall holds a result; the debounce counters
//   and virtual-key state update in the cycle an item reaches the result.
// Reset (synchronous, active high) clears both stages, zeroes the counters,
//   centers the axis and virtual positions and restores limit 8, serial off.
// Stall: while rsp_stall holds a result, one more item is taken into the
//   input register; after that req_stall rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_input_conditioner_assert.svh"
module joystick_input_conditioner #(
   parameter int NUM_BUTTONS = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire jic_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      jic_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [3:0]       csr_index,
   input  wire logic [7:0]       csr_data
);

   logic             s1_valid_ff, s1_valid_in;
   jic_pkg::req_type s1_req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   jic_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0] limit_ff;
   logic       serial_en_ff;

   logic [2:0] last_x_ff, last_y_ff;
   logic [2:0] vx_ff, vy_ff, vx_in, vy_in;
   logic       vx_pend_ff, vy_pend_ff, vx_pend_in, vy_pend_in;
   logic [2:0] last_x_in, last_y_in;

   logic out_load, advance, req_accept;
   jic_pkg::btn_status_type btn;

   logic [2:0] pos_x, pos_y;
   logic       axis_chg, take, seq_ok;
   logic       vxp1, vxp2, vyp1, vyp2;
   logic       left, right, up, down;

   // flow control
   assign out_load   = ~rsp_valid_ff | ~rsp_stall;
   assign advance    = s1_valid_ff & out_load;
   assign req_stall  = s1_valid_ff & ~out_load;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_load ? advance : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= jic_pkg::DEBOUNCE_LIMIT_RESET;
         serial_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            jic_pkg::CSR_DEBOUNCE_LIMIT:     limit_ff     <= csr_data;
            jic_pkg::CSR_SERIAL_KEYS_ENABLE: serial_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   jic_debounce #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_debounce (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .levels  (s1_req_ff.button_levels),
      .limit   (limit_ff),
      .status  (btn)
   );

   always_comb begin
      pos_x    = jic_pkg::POS_MAX - 3'(s1_req_ff.x_sample >> jic_pkg::AXIS_SHIFT);
      pos_y    = 3'(s1_req_ff.y_sample >> jic_pkg::AXIS_SHIFT);
      axis_chg = (pos_x != last_x_ff) || (pos_y != last_y_ff);
      last_x_in = pos_x;
      last_y_in = pos_y;

      take   = ~btn.changed & ~axis_chg & serial_en_ff & s1_req_ff.seq_ready
               & (s1_req_ff.seq_first == jic_pkg::BYTE_ESC);
      seq_ok = take && (s1_req_ff.seq_second == jic_pkg::BYTE_CSI)
               && (s1_req_ff.seq_third >= jic_pkg::KEY_UP)
               && (s1_req_ff.seq_third <= jic_pkg::KEY_LEFT);

      vx_in = vx_ff;
      vy_in = vy_ff;
      vxp1  = vx_pend_ff;
      vyp1  = vy_pend_ff;
      if (seq_ok) begin
         if (s1_req_ff.seq_third == jic_pkg::KEY_UP) begin
            vy_in = jic_pkg::POS_MIN;
            vyp1  = 1'b1;
         end else if (s1_req_ff.seq_third == jic_pkg::KEY_DOWN) begin
            vy_in = jic_pkg::POS_MAX;
            vyp1  = 1'b1;
         end
         if (s1_req_ff.seq_third == jic_pkg::KEY_RIGHT) begin
            vx_in = jic_pkg::POS_MAX;
            vxp1  = 1'b1;
         end else if (s1_req_ff.seq_third == jic_pkg::KEY_LEFT) begin
            vx_in = jic_pkg::POS_MIN;
            vxp1  = 1'b1;
         end
      end

      // a pending virtual key is ORed with the axis direction and is then dropped
      left       = (vxp1 && vx_in <= jic_pkg::POS_LOW) || (pos_x <= jic_pkg::POS_LOW);
      vxp2       = vxp1 && !(vx_in <= jic_pkg::POS_LOW);
      right      = (vxp2 && vx_in >= jic_pkg::POS_HIGH) || (pos_x >= jic_pkg::POS_HIGH);
      vx_pend_in = vxp2 && !(vx_in >= jic_pkg::POS_HIGH);
      up         = (vyp1 && vy_in <= jic_pkg::POS_LOW) || (pos_y <= jic_pkg::POS_LOW);
      vyp2       = vyp1 && !(vy_in <= jic_pkg::POS_LOW);
      down       = (vyp2 && vy_in >= jic_pkg::POS_HIGH) || (pos_y >= jic_pkg::POS_HIGH);
      vy_pend_in = vyp2 && !(vy_in >= jic_pkg::POS_HIGH);

      rsp_in.x_pos           = pos_x;
      rsp_in.y_pos           = pos_y;
      rsp_in.buttons_pressed = btn.pressed;
      rsp_in.changed         = btn.changed | axis_chg | seq_ok;
      rsp_in.dir_left        = left;
      rsp_in.dir_right       = right;
      rsp_in.dir_up          = up;
      rsp_in.dir_down        = down;
      rsp_in.seq_consumed    = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff  <= jic_pkg::POS_CENTER;
         last_y_ff  <= jic_pkg::POS_CENTER;
         vx_ff      <= jic_pkg::POS_CENTER;
         vy_ff      <= jic_pkg::POS_CENTER;
         vx_pend_ff <= 1'b0;
         vy_pend_ff <= 1'b0;
      end else if (advance) begin
         last_x_ff  <= last_x_in;
         last_y_ff  <= last_y_in;
         vx_ff      <= vx_in;
         vy_ff      <= vy_in;
         vx_pend_ff <= vx_pend_in;
         vy_pend_ff <= vy_pend_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `JIC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_req_ff))
   `JIC_ASSERT_IMPL(a_stall_needs_item, clock, reset, !s1_valid_ff, !req_stall)
   `JIC_ASSERT(a_pending_reported, clock, reset, !vx_pend_ff && !vy_pend_ff)
   `JIC_ASSERT_IMPL(a_key_sets_dir, clock, reset,
      rsp_valid_ff && rsp_ff.seq_consumed && rsp_ff.changed,
      rsp_ff.dir_left || rsp_ff.dir_right || rsp_ff.dir_up || rsp_ff.dir_down)

endmodule
`default_nettype wire
